>>> src/tfe_pkg.sv
// ----------------------------------------------------------------------------
// tfe_pkg: shared types and constants for the telemetry frame encoder
// Request and result payloads, queue entry, register file and sequencer phases.
// ----------------------------------------------------------------------------
package tfe_pkg;

  // Frame kinds
  localparam logic OP_ATTITUDE = 1'b0;
  localparam logic OP_ALTITUDE = 1'b1;

  // Register indexes on the configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEST    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ATT_ID  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALT_ID  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRAILER = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_HEADER  = 8'hAA;
  localparam logic [7:0] RST_DEST    = 8'hFF;
  localparam logic [7:0] RST_ATT_ID  = 8'h04;
  localparam logic [7:0] RST_ALT_ID  = 8'h05;
  localparam logic [7:0] RST_TRAILER = 8'h01;

  // Payload length bytes and payload byte counts
  localparam logic [7:0] ATT_LEN = 8'd9;
  localparam logic [7:0] ALT_LEN = 8'd13;
  localparam logic [3:0] ATT_PAY_LAST = 4'd7;   // 8 payload bytes
  localparam logic [3:0] ALT_PAY_LAST = 4'd11;  // 4 altitude bytes + 8 zeros

  // Queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic               op;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] altitude_cm;
  } tfe_req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } tfe_res_t;

  // Classified frame: kind plus payload bytes, byte 0 in the low bits
  typedef struct packed {
    logic        alt;
    logic [63:0] payload;
  } tfe_entry_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] dest_address;
    logic [7:0] attitude_frame_id;
    logic [7:0] altitude_frame_id;
    logic [7:0] trailer_byte;
  } tfe_cfg_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HEAD,
    PH_DEST,
    PH_ID,
    PH_LEN,
    PH_PAY,
    PH_TRAIL,
    PH_SUM,
    PH_ADD
  } tfe_phase_t;

endpackage

>>> src/telemetry_frame_encoder.sv
// ----------------------------------------------------------------------------
// telemetry_frame_encoder: serial telemetry frame generator
// Turns attitude or altitude requests into framed bytes with sum/add checks.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------
//  request   start / busy           req   (op, quat_w..z, altitude_cm)
//  result    res_strobe (no stall)  res   (frame_byte, last_byte)
//  config    cfg_we                 cfg_index, cfg_data (8 bits)
//
//  A frame is 15 (attitude) or 19 (altitude) bytes, one byte per cycle,
//  sent by the serializer; frames follow each other with no gap while requests are queued.
//  The first byte passes through the queue, the serializer phase register and the res register.
//  A two-entry queue holds requests; busy rises only when it is full.
//  Synchronous reset restores the register defaults and empties the queue.
//  The receiver cannot stall: every strobed byte is taken.
// ----------------------------------------------------------------------------
module telemetry_frame_encoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  tfe_pkg::tfe_req_t                 req,
  output logic                              res_strobe,
  output tfe_pkg::tfe_res_t                 res,
  input  logic                              cfg_we,
  input  logic [tfe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]                        cfg_data
);

  tfe_pkg::tfe_cfg_t   cfg;
  tfe_pkg::tfe_entry_t push_entry;
  tfe_pkg::tfe_entry_t head;
  logic                push;
  logic                pop;
  logic                q_not_empty;
  logic                q_full;

  // Register file writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte       <= tfe_pkg::RST_HEADER;
      cfg.dest_address      <= tfe_pkg::RST_DEST;
      cfg.attitude_frame_id <= tfe_pkg::RST_ATT_ID;
      cfg.altitude_frame_id <= tfe_pkg::RST_ALT_ID;
      cfg.trailer_byte      <= tfe_pkg::RST_TRAILER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfe_pkg::CFG_HEADER:  cfg.header_byte       <= cfg_data;
        tfe_pkg::CFG_DEST:    cfg.dest_address      <= cfg_data;
        tfe_pkg::CFG_ATT_ID:  cfg.attitude_frame_id <= cfg_data;
        tfe_pkg::CFG_ALT_ID:  cfg.altitude_frame_id <= cfg_data;
        tfe_pkg::CFG_TRAILER: cfg.trailer_byte      <= cfg_data;
        default:              cfg <= cfg;
      endcase
    end
  end

  tfe_front u_front (
    .start  (start),
    .req    (req),
    .q_full (q_full),
    .busy   (busy),
    .push   (push),
    .entry  (push_entry)
  );

  tfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  tfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .res_strobe  (res_strobe),
    .res         (res)
  );

endmodule

>>> src/tfe_front.sv
// ----------------------------------------------------------------------------
// tfe_front: request intake
// Accepts frame requests and packs the payload bytes of the chosen frame kind.
// ----------------------------------------------------------------------------
module tfe_front (
  input  logic               start,
  input  tfe_pkg::tfe_req_t  req,
  input  logic               q_full,
  output logic               busy,
  output logic               push,
  output tfe_pkg::tfe_entry_t entry
);

  // Stall intake while the queue is full
  assign busy = q_full;
  assign push = start && !q_full;

  // Classify the request and lay out its payload in transmit order
  always_comb begin
    entry.alt = (req.op == tfe_pkg::OP_ALTITUDE);
    if (entry.alt) begin
      entry.payload = {32'd0, req.altitude_cm};
    end else begin
      entry.payload = {req.quat_z, req.quat_y, req.quat_x, req.quat_w};
    end
  end

endmodule

>>> src/tfe_queue.sv
// ----------------------------------------------------------------------------
// tfe_queue: classified frame queue
// Small first-in first-out store that decouples intake from serialization.
// ----------------------------------------------------------------------------
module tfe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tfe_pkg::tfe_entry_t push_entry,
  input  logic                pop,
  output tfe_pkg::tfe_entry_t head,
  output logic                not_empty,
  output logic                full
);

  localparam int unsigned PTR_W = $clog2(tfe_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(tfe_pkg::QUEUE_DEPTH + 1);

  tfe_pkg::tfe_entry_t slots [tfe_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wptr;
  logic [PTR_W-1:0]    rptr;
  logic [CNT_W-1:0]    count;

  assign head      = slots[rptr];
  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(tfe_pkg::QUEUE_DEPTH));

  // Write entry data
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(tfe_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(tfe_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

>>> src/tfe_back.sv
// ----------------------------------------------------------------------------
// tfe_back: frame serializer
// Emits one frame byte per cycle during a frame and accumulates the sum and add checks.
// ----------------------------------------------------------------------------
module tfe_back (
  input  logic                clk,
  input  logic                rst,
  input  tfe_pkg::tfe_cfg_t   cfg,
  input  tfe_pkg::tfe_entry_t head,
  input  logic                q_not_empty,
  output logic                pop,
  output logic                res_strobe,
  output tfe_pkg::tfe_res_t   res
);

  tfe_pkg::tfe_phase_t phase;
  tfe_pkg::tfe_phase_t phase_next;
  logic                cur_alt;
  logic [63:0]         cur_payload;
  logic [3:0]          pidx;
  logic                pay_last;
  logic [7:0]          pay_byte;
  logic [7:0]          sum_chk;
  logic [7:0]          add_chk;
  logic [7:0]          sum_next;
  logic [7:0]          cur_byte;
  logic                cur_last;

  // Take the next frame at the end of the current one, or when idle
  assign pop = q_not_empty && (phase == tfe_pkg::PH_IDLE || phase == tfe_pkg::PH_ADD);

  // Select payload byte; bytes past the stored eight are zero fill
  assign pay_byte = pidx[3] ? 8'd0 : cur_payload[{pidx[2:0], 3'b000} +: 8];
  assign pay_last = (pidx == (cur_alt ? tfe_pkg::ALT_PAY_LAST : tfe_pkg::ATT_PAY_LAST));

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      tfe_pkg::PH_IDLE:  phase_next = pop ? tfe_pkg::PH_HEAD : tfe_pkg::PH_IDLE;
      tfe_pkg::PH_HEAD:  phase_next = tfe_pkg::PH_DEST;
      tfe_pkg::PH_DEST:  phase_next = tfe_pkg::PH_ID;
      tfe_pkg::PH_ID:    phase_next = tfe_pkg::PH_LEN;
      tfe_pkg::PH_LEN:   phase_next = tfe_pkg::PH_PAY;
      tfe_pkg::PH_PAY:   phase_next = pay_last ? tfe_pkg::PH_TRAIL : tfe_pkg::PH_PAY;
      tfe_pkg::PH_TRAIL: phase_next = tfe_pkg::PH_SUM;
      tfe_pkg::PH_SUM:   phase_next = tfe_pkg::PH_ADD;
      tfe_pkg::PH_ADD:   phase_next = pop ? tfe_pkg::PH_HEAD : tfe_pkg::PH_IDLE;
      default:           phase_next = tfe_pkg::PH_IDLE;
    endcase
  end

  // Byte for the current phase
  always_comb begin
    cur_byte = 8'd0;
    cur_last = 1'b0;
    unique case (phase)
      tfe_pkg::PH_IDLE:  cur_byte = 8'd0;
      tfe_pkg::PH_HEAD:  cur_byte = cfg.header_byte;
      tfe_pkg::PH_DEST:  cur_byte = cfg.dest_address;
      tfe_pkg::PH_ID:    cur_byte = cur_alt ? cfg.altitude_frame_id : cfg.attitude_frame_id;
      tfe_pkg::PH_LEN:   cur_byte = cur_alt ? tfe_pkg::ALT_LEN : tfe_pkg::ATT_LEN;
      tfe_pkg::PH_PAY:   cur_byte = pay_byte;
      tfe_pkg::PH_TRAIL: cur_byte = cfg.trailer_byte;
      tfe_pkg::PH_SUM:   cur_byte = sum_chk;
      tfe_pkg::PH_ADD: begin
        cur_byte = add_chk;
        cur_last = 1'b1;
      end
      default:           cur_byte = 8'd0;
    endcase
  end

  assign sum_next = sum_chk + cur_byte;

  // Advance phase and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= tfe_pkg::PH_IDLE;
      res_strobe <= 1'b0;
    end else begin
      phase      <= phase_next;
      res_strobe <= (phase != tfe_pkg::PH_IDLE);
    end
  end

  // Load frame, count payload bytes, accumulate checks, register the result
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_alt     <= head.alt;
      cur_payload <= head.payload;
    end
    pidx <= (phase == tfe_pkg::PH_PAY) ? pidx + 1'b1 : 4'd0;
    case (phase)
      tfe_pkg::PH_HEAD: begin
        sum_chk <= cur_byte;
        add_chk <= cur_byte;
      end
      tfe_pkg::PH_DEST, tfe_pkg::PH_ID, tfe_pkg::PH_LEN, tfe_pkg::PH_PAY,
      tfe_pkg::PH_TRAIL: begin
        sum_chk <= sum_next;
        add_chk <= add_chk + sum_next;
      end
      default: begin
        sum_chk <= sum_chk;
        add_chk <= add_chk;
      end
    endcase
    res.frame_byte <= cur_byte;
    res.last_byte  <= cur_last;
  end

  a_last_strobed: assert property (@(posedge clk) disable iff (rst)
    (res_strobe && res.last_byte) |-> $past(phase == tfe_pkg::PH_ADD))
    else $error("last byte flagged outside the add check");

  a_add_is_last: assert property (@(posedge clk) disable iff (rst)
    (phase == tfe_pkg::PH_ADD) |=> (res_strobe && res.last_byte))
    else $error("add check not flagged as last byte");

  a_pay_to_trail: assert property (@(posedge clk) disable iff (rst)
    (phase == tfe_pkg::PH_PAY && pay_last) |=> (phase == tfe_pkg::PH_TRAIL))
    else $error("payload did not end in trailer");

endmodule
